// ===== src/deq_pkg.sv =====
package deq_pkg;

  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    logic fill;
    logic load;
  } deq_cmd_t;

  typedef struct packed {
    logic need_fill;
  } deq_stat_t;

endpackage

// ===== src/deq_ram.sv =====
module deq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/deq_ctrl.sv =====
module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  deq_stat_t stat,
  output deq_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_FILL = 4'b0100,
    S_LOAD = 4'b1000
  } deq_state_t;

  deq_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_fill ? S_FILL : S_LOAD;
      end
      S_FILL: begin
        cmd.fill  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (!out_valid_r || out_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/deq_dpath.sv =====
module deq_dpath
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  deq_cmd_t                     cmd,
  output deq_stat_t                    stat,
  input  logic [OPCODE_W-1:0]          in_opcode,
  input  logic [DATA_WIDTH-1:0]        in_push_value,
  output logic [DATA_WIDTH-1:0]        out_popped_value,
  output logic [DATA_WIDTH-1:0]        out_front_value,
  output logic [DATA_WIDTH-1:0]        out_back_value,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic [STATUS_W-1:0]          out_status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
    return (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
    return (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
  endfunction

  logic [OPCODE_W-1:0]   op_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [AW-1:0]         front_idx_r, front_idx_nxt;
  logic [AW-1:0]         back_idx_r, back_idx_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] front_r, front_nxt;
  logic [DATA_WIDTH-1:0] back_r, back_nxt;
  logic [DATA_WIDTH-1:0] popped_r, popped_nxt;
  logic [STATUS_W-1:0]   status_r, status_nxt;
  logic                  fill_front_r, fill_front_nxt;

  logic [DATA_WIDTH-1:0] out_popped_r, out_front_r, out_back_r;
  logic [CW-1:0]         out_count_r;
  logic [STATUS_W-1:0]   out_status_r;

  logic                  is_full, is_empty;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  assign is_full  = (count_r == CW'(DEPTH));
  assign is_empty = (count_r == '0);

  // pops on a non-empty queue refetch the new end word
  assign stat.need_fill = ((op_r == OP_POP_FRONT) || (op_r == OP_POP_BACK)) && !is_empty;
  assign rd_addr        = (op_r == OP_POP_FRONT) ? idx_inc(front_idx_r) : idx_dec(back_idx_r);

  always_comb begin
    front_idx_nxt  = front_idx_r;
    back_idx_nxt   = back_idx_r;
    count_nxt      = count_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    popped_nxt     = popped_r;
    status_nxt     = status_r;
    fill_front_nxt = fill_front_r;
    wr_en          = 1'b0;
    wr_addr        = idx_inc(back_idx_r);
    if (cmd.exec) begin
      popped_nxt = '0;
      status_nxt = ST_DONE;
      case (op_r)
        OP_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = idx_inc(back_idx_r);
            back_idx_nxt = idx_inc(back_idx_r);
            back_nxt     = val_r;
            if (is_empty) begin
              front_nxt = val_r;
            end
            count_nxt = count_r + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en         = 1'b1;
            wr_addr       = idx_dec(front_idx_r);
            front_idx_nxt = idx_dec(front_idx_r);
            front_nxt     = val_r;
            if (is_empty) begin
              back_nxt = val_r;
            end
            count_nxt = count_r + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt     = front_r;
            front_idx_nxt  = idx_inc(front_idx_r);
            count_nxt      = count_r - CW'(1);
            fill_front_nxt = 1'b1;
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            popped_nxt     = back_r;
            back_idx_nxt   = idx_dec(back_idx_r);
            count_nxt      = count_r - CW'(1);
            fill_front_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.fill) begin
      if (fill_front_r) begin
        front_nxt = rd_data;
      end else begin
        back_nxt = rd_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_idx_r <= '0;
      back_idx_r  <= AW'(DEPTH - 1);
      count_r     <= '0;
    end else begin
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_opcode;
      val_r <= in_push_value;
    end
    front_r      <= front_nxt;
    back_r       <= back_nxt;
    popped_r     <= popped_nxt;
    status_r     <= status_nxt;
    fill_front_r <= fill_front_nxt;
    if (cmd.load) begin
      out_popped_r <= popped_r;
      out_front_r  <= is_empty ? '0 : front_r;
      out_back_r   <= is_empty ? '0 : back_r;
      out_count_r  <= count_r;
      out_status_r <= status_r;
    end
  end

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_r),
    .rd_en   (cmd.exec),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_popped_value = out_popped_r;
  assign out_front_value  = out_front_r;
  assign out_back_value   = out_back_r;
  assign out_entry_count  = out_count_r;
  assign out_status       = out_status_r;

endmodule

// ===== src/double_ended_queue.sv =====
// an item is captured in idle, then passes exec, a fill state for a pop that succeeds,
//   and load, which waits while an unaccepted result is held, then sets out_valid; the fill
//   state is the registered read of the word store that refetches the new front or back word
// a finished result waits in the output register while the next item is taken in
// reset: synchronous, active low; clears the state machine, pointers, count and
//   out_valid; the word store is not cleared
module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [OPCODE_W-1:0]        in_opcode,
  input  logic [DATA_WIDTH-1:0]      in_push_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [DATA_WIDTH-1:0]      out_popped_value,
  output logic [DATA_WIDTH-1:0]      out_front_value,
  output logic [DATA_WIDTH-1:0]      out_back_value,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  output logic [STATUS_W-1:0]        out_status
);

  localparam int CW = $clog2(DEPTH + 1);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  deq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_opcode        (in_opcode),
    .in_push_value    (in_push_value),
    .out_popped_value (out_popped_value),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value),
    .out_entry_count  (out_entry_count),
    .out_status       (out_status)
  );

`ifndef SYNTHESIS
  // one item in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_entry_count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_entry_count == CW'(DEPTH))
    else $error("full status with room left");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |->
      out_entry_count == '0 && out_popped_value == '0 && out_front_value == '0)
    else $error("empty status with stored words or popped word");
`endif

endmodule
